>>> src/modbus_rtu_slave_responder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Modbus RTU slave responder
// Shared concurrent-assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_SLAVE_RESPONDER_TOP_ASSERT_SVH
`define MODBUS_RTU_SLAVE_RESPONDER_TOP_ASSERT_SVH

// same-cycle implication
`define MRS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Types, codes and the CRC-16 byte step shared by the responder modules.
// ----------------------------------------------------------------------------
package mrs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_STATION     = 3'd0;
  localparam logic [2:0] CFG_HOLD_BASE   = 3'd1;
  localparam logic [2:0] CFG_HOLD_COUNT  = 3'd2;
  localparam logic [2:0] CFG_COIL_BASE   = 3'd3;
  localparam logic [2:0] CFG_COIL_COUNT  = 3'd4;

  // frame status codes
  localparam logic [2:0] ST_TAKEN     = 3'd0;
  localparam logic [2:0] ST_REPLY     = 3'd1;
  localparam logic [2:0] ST_EXCEPTION = 3'd2;
  localparam logic [2:0] ST_CRC_BAD   = 3'd3;
  localparam logic [2:0] ST_NOT_ADDR  = 3'd4;
  localparam logic [2:0] ST_SHORT     = 3'd5;
  localparam logic [2:0] ST_OVERFLOW  = 3'd6;

  // function codes
  localparam logic [7:0] FN_RD_COILS = 8'h01;
  localparam logic [7:0] FN_RD_HOLD  = 8'h03;
  localparam logic [7:0] FN_WR_COIL  = 8'h05;
  localparam logic [7:0] FN_WR_HOLD  = 8'h06;
  localparam logic [7:0] FN_WR_MULTI = 8'h10;

  // exception codes
  localparam logic [1:0] EXC_NONE  = 2'd0;
  localparam logic [1:0] EXC_FUNC  = 2'd1;
  localparam logic [1:0] EXC_ADDR  = 2'd2;
  localparam logic [1:0] EXC_VALUE = 2'd3;

  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] COIL_ON    = 16'hFF00;
  localparam logic [7:0]  EXC_FLAG   = 8'h80;
  localparam logic [15:0] MAX_RD_REG = 16'd125;
  localparam logic [15:0] MAX_WR_REG = 16'd123;
  localparam logic [15:0] MAX_COILS  = 16'd2000;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CLASSIFY, S_DECODE, S_ROUTE, S_WR1, S_HDR,
    S_HRD, S_HHI, S_HLO, S_FR1, S_FR2, S_FR3, S_CRD, S_CBIT, S_CPUT,
    S_SEAL_LO, S_SEAL_HI, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_CLASSIFY, OP_DECODE, OP_ROUTE, OP_WR1, OP_HDR,
    OP_HHI, OP_HLO, OP_FR1, OP_FR2, OP_FR3, OP_CBIT, OP_CPUT,
    OP_SEAL_LO, OP_SEAL_HI, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    K_EXC, K_ECHO, K_RD_HOLD, K_RD_COIL, K_WR_MANY
  } kind_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic  clr_done;
    logic  is_fetch;
    logic  is_end;
    logic  serve;
    kind_t kind;
    logic  hdr_last;
    logic  loop_last;
    logic  byte_end;
    logic  coil_done;
    logic  out_free;
  } sts_t;

  // one byte of CRC-16, reflected polynomial
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

>>> src/mrs_ctrl.sv
// ----------------------------------------------------------------------------
// mrs_ctrl
// Sequencer: accepts words, walks frame checks, request service and reply build.
// ----------------------------------------------------------------------------
module mrs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mrs_pkg::sts_t sts,
  output mrs_pkg::cmd_t cmd
);

  mrs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrs_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != mrs_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.op     = mrs_pkg::OP_NONE;
    case (state_r)
      mrs_pkg::S_CLEAR: begin
        cmd.op = mrs_pkg::OP_CLEAR;
        if (sts.clr_done) state_nxt = mrs_pkg::S_IDLE;
      end
      mrs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (!sts.is_fetch && sts.is_end) state_nxt = mrs_pkg::S_CLASSIFY;
          else state_nxt = mrs_pkg::S_EMIT;
        end
      end
      mrs_pkg::S_CLASSIFY: begin
        cmd.op    = mrs_pkg::OP_CLASSIFY;
        state_nxt = sts.serve ? mrs_pkg::S_DECODE : mrs_pkg::S_EMIT;
      end
      mrs_pkg::S_DECODE: begin
        cmd.op    = mrs_pkg::OP_DECODE;
        state_nxt = mrs_pkg::S_ROUTE;
      end
      mrs_pkg::S_ROUTE: begin
        cmd.op = mrs_pkg::OP_ROUTE;
        case (sts.kind)
          mrs_pkg::K_ECHO:    state_nxt = mrs_pkg::S_WR1;
          mrs_pkg::K_WR_MANY: state_nxt = mrs_pkg::S_FR1;
          default:            state_nxt = mrs_pkg::S_HDR;
        endcase
      end
      mrs_pkg::S_WR1: begin
        cmd.op    = mrs_pkg::OP_WR1;
        state_nxt = mrs_pkg::S_HDR;
      end
      mrs_pkg::S_HDR: begin
        cmd.op = mrs_pkg::OP_HDR;
        if (sts.hdr_last) begin
          case (sts.kind)
            mrs_pkg::K_RD_HOLD: state_nxt = mrs_pkg::S_HRD;
            mrs_pkg::K_RD_COIL: state_nxt = mrs_pkg::S_CRD;
            default:            state_nxt = mrs_pkg::S_SEAL_LO;
          endcase
        end
      end
      mrs_pkg::S_HRD: state_nxt = mrs_pkg::S_HHI;
      mrs_pkg::S_HHI: begin
        cmd.op    = mrs_pkg::OP_HHI;
        state_nxt = mrs_pkg::S_HLO;
      end
      mrs_pkg::S_HLO: begin
        cmd.op    = mrs_pkg::OP_HLO;
        state_nxt = sts.loop_last ? mrs_pkg::S_SEAL_LO : mrs_pkg::S_HRD;
      end
      mrs_pkg::S_FR1: begin
        cmd.op    = mrs_pkg::OP_FR1;
        state_nxt = mrs_pkg::S_FR2;
      end
      mrs_pkg::S_FR2: begin
        cmd.op    = mrs_pkg::OP_FR2;
        state_nxt = mrs_pkg::S_FR3;
      end
      mrs_pkg::S_FR3: begin
        cmd.op    = mrs_pkg::OP_FR3;
        state_nxt = sts.loop_last ? mrs_pkg::S_HDR : mrs_pkg::S_FR1;
      end
      mrs_pkg::S_CRD: state_nxt = mrs_pkg::S_CBIT;
      mrs_pkg::S_CBIT: begin
        cmd.op    = mrs_pkg::OP_CBIT;
        state_nxt = sts.byte_end ? mrs_pkg::S_CPUT : mrs_pkg::S_CRD;
      end
      mrs_pkg::S_CPUT: begin
        cmd.op    = mrs_pkg::OP_CPUT;
        state_nxt = sts.coil_done ? mrs_pkg::S_SEAL_LO : mrs_pkg::S_CRD;
      end
      mrs_pkg::S_SEAL_LO: begin
        cmd.op    = mrs_pkg::OP_SEAL_LO;
        state_nxt = mrs_pkg::S_SEAL_HI;
      end
      mrs_pkg::S_SEAL_HI: begin
        cmd.op    = mrs_pkg::OP_SEAL_HI;
        state_nxt = mrs_pkg::S_EMIT;
      end
      mrs_pkg::S_EMIT: begin
        // hold until the output register can take the word
        if (sts.out_free) begin
          cmd.op    = mrs_pkg::OP_EMIT;
          state_nxt = mrs_pkg::S_IDLE;
        end
      end
      default: state_nxt = mrs_pkg::S_IDLE;
    endcase
  end

endmodule

>>> src/mrs_dp.sv
// ----------------------------------------------------------------------------
// mrs_dp
// Datapath: frame, holding, coil and reply stores, checks, tallies, output.
// ----------------------------------------------------------------------------
`include "modbus_rtu_slave_responder_top_assert.svh"

module mrs_dp #(
  parameter int FRAME_BYTES   = 256,
  parameter int HOLDING_DEPTH = 128,
  parameter int COIL_DEPTH    = 2048
) (
  input  logic          clk,
  input  logic          rst_n,
  input  mrs_pkg::cmd_t cmd,
  output mrs_pkg::sts_t sts,
  input  logic          in_command,
  input  logic [7:0]    in_rx_byte,
  input  logic          in_frame_end,
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_wdata,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_tx_byte,
  output logic          out_tx_valid,
  output logic          out_tx_last,
  output logic [2:0]    out_frame_status,
  output logic [8:0]    out_reply_size,
  output logic [15:0]   out_error_total,
  output logic [15:0]   out_request_total
);

  localparam int FA    = $clog2(FRAME_BYTES);
  localparam int HA    = (HOLDING_DEPTH > 1) ? $clog2(HOLDING_DEPTH) : 1;
  localparam int CA    = (COIL_DEPTH > 1) ? $clog2(COIL_DEPTH) : 1;
  localparam int CLR_N = (HOLDING_DEPTH > COIL_DEPTH) ? HOLDING_DEPTH : COIL_DEPTH;
  localparam int CLW   = $clog2(CLR_N);

  localparam logic [FA:0]  FLEN_MAX  = (FA+1)'(FRAME_BYTES);
  localparam logic [FA:0]  HDR_BYTES = (FA+1)'(7);
  localparam logic [CLW:0] CLR_LAST  = (CLW+1)'(CLR_N - 1);
  localparam logic [CLW:0] CLR_HOLD  = (CLW+1)'(HOLDING_DEPTH);
  localparam logic [CLW:0] CLR_COIL  = (CLW+1)'(COIL_DEPTH);
  localparam logic [16:0]  HD_W      = 17'(HOLDING_DEPTH);
  localparam logic [16:0]  CD_W      = 17'(COIL_DEPTH);

  // stores
  logic [7:0]  frame_mem [FRAME_BYTES];
  logic [15:0] hold_mem  [HOLDING_DEPTH];
  logic        coil_mem  [COIL_DEPTH];
  logic [7:0]  reply_mem [256];

  // configuration
  logic [7:0]  station_r;
  logic [15:0] hbase_r, cbase_r;
  logic [7:0]  hcount_r;
  logic [11:0] ccount_r;

  // receive side
  logic [FA:0]  flen_r;
  logic         ovf_r, ovf_seen_r, crc_ok_r, fetch_r;
  logic [15:0]  c0_r, c1_r;
  logic [7:0]   prev_r;
  logic [7:0]   hdr_r [7];
  logic [8:0]   len_r;

  // service
  logic [CLW:0] clr_r;
  logic [2:0]   st_r;
  logic [1:0]   exc_r;
  mrs_pkg::kind_t kind_r;
  logic [15:0]  off_r;
  logic [11:0]  i_r;
  logic [2:0]   k_r;
  logic [7:0]   v_r, hi_r;
  logic [15:0]  hrd_r;
  logic         crd_r;
  logic [7:0]   frd_r, rrd_r;
  logic [15:0]  crc_r;
  logic [8:0]   rlen_r, ptr_r;
  logic [15:0]  err_r, req_r;

  // output register
  logic         out_valid_r;
  logic [7:0]   tx_byte_r;
  logic         tx_valid_r, tx_last_r;
  logic [2:0]   status_r;
  logic [8:0]   size_r;
  logic [15:0]  err_out_r, req_out_r;

  logic        recv, full;
  logic [7:0]  fn;
  logic [15:0] adr, cnt;
  logic [7:0]  bc;
  logic [16:0] effh, effc, htop, ctop, base17, top17, end17, nb17;
  logic        is_hold_fn, known_fn, serve;
  logic [1:0]  exc_nxt;
  mrs_pkg::kind_t kind_nxt;
  logic [16:0] hsum, csum;
  logic [12:0] fsum;
  logic [HA-1:0] haddr;
  logic [CA-1:0] caddr;
  logic [FA-1:0] faddr;
  logic        put_en, put_crc, hdr_last, out_free;
  logic [7:0]  put_byte, hdr_byte;

  assign recv     = cmd.accept && !in_command;
  assign full     = (flen_r == FLEN_MAX);
  assign out_free = !out_valid_r || !out_stall;

  // request fields
  assign fn  = hdr_r[1];
  assign adr = {hdr_r[2], hdr_r[3]};
  assign cnt = {hdr_r[4], hdr_r[5]};
  assign bc  = hdr_r[6];

  assign effh = ({9'd0, hcount_r} < HD_W) ? {9'd0, hcount_r} : HD_W;
  assign effc = ({5'd0, ccount_r} < CD_W) ? {5'd0, ccount_r} : CD_W;
  assign htop = {1'b0, hbase_r} + effh;
  assign ctop = {1'b0, cbase_r} + effc;
  assign is_hold_fn = (fn == mrs_pkg::FN_RD_HOLD) || (fn == mrs_pkg::FN_WR_HOLD) ||
                      (fn == mrs_pkg::FN_WR_MULTI);
  assign known_fn   = is_hold_fn || (fn == mrs_pkg::FN_RD_COILS) ||
                      (fn == mrs_pkg::FN_WR_COIL);
  assign base17 = is_hold_fn ? {1'b0, hbase_r} : {1'b0, cbase_r};
  assign top17  = is_hold_fn ? htop : ctop;
  assign end17  = {1'b0, adr} + {1'b0, cnt};
  assign nb17   = {1'b0, cnt} + 17'd7;

  assign serve = !ovf_seen_r && (len_r >= 9'd5) && crc_ok_r && (hdr_r[0] == station_r);

  always_comb begin
    exc_nxt = mrs_pkg::EXC_NONE;
    if (!known_fn) begin
      exc_nxt = mrs_pkg::EXC_FUNC;
    end else if (len_r < 9'd8) begin
      exc_nxt = mrs_pkg::EXC_VALUE;
    end else if ((fn == mrs_pkg::FN_RD_HOLD) &&
                 (cnt == 16'd0 || cnt > mrs_pkg::MAX_RD_REG)) begin
      exc_nxt = mrs_pkg::EXC_VALUE;
    end else if ((fn == mrs_pkg::FN_WR_MULTI) &&
                 (len_r < 9'd9 || cnt == 16'd0 || cnt > mrs_pkg::MAX_WR_REG ||
                  {9'd0, bc} != {cnt, 1'b0} ||
                  {1'b0, len_r} < (10'd9 + {2'd0, bc}))) begin
      exc_nxt = mrs_pkg::EXC_VALUE;
    end else if ((fn == mrs_pkg::FN_RD_COILS) &&
                 (cnt == 16'd0 || cnt > mrs_pkg::MAX_COILS)) begin
      exc_nxt = mrs_pkg::EXC_VALUE;
    end else if ({1'b0, adr} < base17 || {1'b0, adr} >= top17) begin
      exc_nxt = mrs_pkg::EXC_ADDR;
    end else if ((fn == mrs_pkg::FN_RD_HOLD || fn == mrs_pkg::FN_WR_MULTI ||
                  fn == mrs_pkg::FN_RD_COILS) && end17 > top17) begin
      exc_nxt = mrs_pkg::EXC_ADDR;
    end
  end

  always_comb begin
    if (exc_nxt != mrs_pkg::EXC_NONE) kind_nxt = mrs_pkg::K_EXC;
    else if (fn == mrs_pkg::FN_RD_HOLD) kind_nxt = mrs_pkg::K_RD_HOLD;
    else if (fn == mrs_pkg::FN_RD_COILS) kind_nxt = mrs_pkg::K_RD_COIL;
    else if (fn == mrs_pkg::FN_WR_MULTI) kind_nxt = mrs_pkg::K_WR_MANY;
    else kind_nxt = mrs_pkg::K_ECHO;
  end

  // store addresses
  assign hsum  = {1'b0, off_r} + {5'd0, i_r};
  assign csum  = hsum;
  assign haddr = hsum[HA-1:0];
  assign caddr = csum[CA-1:0];
  assign fsum  = {i_r, 1'b0} + ((cmd.op == mrs_pkg::OP_FR1) ? 13'd7 : 13'd8);
  assign faddr = fsum[FA-1:0];

  // reply header bytes
  always_comb begin
    hdr_byte = 8'd0;
    case (kind_r)
      mrs_pkg::K_EXC: begin
        case (k_r)
          3'd0:    hdr_byte = station_r;
          3'd1:    hdr_byte = fn | mrs_pkg::EXC_FLAG;
          default: hdr_byte = {6'd0, exc_r};
        endcase
      end
      mrs_pkg::K_ECHO: hdr_byte = hdr_r[k_r];
      mrs_pkg::K_RD_HOLD: begin
        case (k_r)
          3'd0:    hdr_byte = station_r;
          3'd1:    hdr_byte = fn;
          default: hdr_byte = {cnt[6:0], 1'b0};
        endcase
      end
      mrs_pkg::K_RD_COIL: begin
        case (k_r)
          3'd0:    hdr_byte = station_r;
          3'd1:    hdr_byte = fn;
          default: hdr_byte = nb17[10:3];
        endcase
      end
      mrs_pkg::K_WR_MANY: begin
        case (k_r)
          3'd0:    hdr_byte = station_r;
          3'd1:    hdr_byte = fn;
          3'd2:    hdr_byte = hdr_r[2];
          3'd3:    hdr_byte = hdr_r[3];
          3'd4:    hdr_byte = hdr_r[4];
          default: hdr_byte = hdr_r[5];
        endcase
      end
      default: hdr_byte = 8'd0;
    endcase
  end

  assign hdr_last = (kind_r == mrs_pkg::K_ECHO || kind_r == mrs_pkg::K_WR_MANY) ?
                    (k_r == 3'd5) : (k_r == 3'd2);

  always_comb begin
    put_en   = 1'b1;
    put_crc  = 1'b1;
    put_byte = 8'd0;
    case (cmd.op)
      mrs_pkg::OP_HDR:     put_byte = hdr_byte;
      mrs_pkg::OP_HHI:     put_byte = hrd_r[15:8];
      mrs_pkg::OP_HLO:     put_byte = hrd_r[7:0];
      mrs_pkg::OP_CPUT:    put_byte = v_r;
      mrs_pkg::OP_SEAL_LO: begin
        put_byte = crc_r[7:0];
        put_crc  = 1'b0;
      end
      mrs_pkg::OP_SEAL_HI: begin
        put_byte = crc_r[15:8];
        put_crc  = 1'b0;
      end
      default: put_en = 1'b0;
    endcase
  end

  assign sts.clr_done  = (clr_r == CLR_LAST);
  assign sts.is_fetch  = in_command;
  assign sts.is_end    = in_frame_end;
  assign sts.serve     = serve;
  assign sts.kind      = kind_r;
  assign sts.hdr_last  = hdr_last;
  assign sts.loop_last = (({4'd0, i_r} + 16'd1) == cnt);
  assign sts.byte_end  = (i_r[2:0] == 3'd7);
  assign sts.coil_done = ({5'd0, i_r[11:3]} == nb17[16:3]);
  assign sts.out_free  = out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= 8'd1;
      hbase_r   <= 16'd0;
      hcount_r  <= 8'd0;
      cbase_r   <= 16'd0;
      ccount_r  <= 12'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mrs_pkg::CFG_STATION:    station_r <= cfg_wdata[7:0];
        mrs_pkg::CFG_HOLD_BASE:  hbase_r   <= cfg_wdata;
        mrs_pkg::CFG_HOLD_COUNT: hcount_r  <= cfg_wdata[7:0];
        mrs_pkg::CFG_COIL_BASE:  cbase_r   <= cfg_wdata;
        mrs_pkg::CFG_COIL_COUNT: ccount_r  <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (recv && !full) frame_mem[flen_r[FA-1:0]] <= in_rx_byte;
    frd_r <= frame_mem[faddr];
  end

  // holding store: clearing sweep, single writes, multi-write loop
  always_ff @(posedge clk) begin
    if (cmd.op == mrs_pkg::OP_CLEAR && clr_r < CLR_HOLD) begin
      hold_mem[clr_r[HA-1:0]] <= 16'd0;
    end else if (cmd.op == mrs_pkg::OP_WR1 && fn == mrs_pkg::FN_WR_HOLD) begin
      hold_mem[off_r[HA-1:0]] <= cnt;
    end else if (cmd.op == mrs_pkg::OP_FR3) begin
      hold_mem[haddr] <= {hi_r, frd_r};
    end
    hrd_r <= hold_mem[haddr];
  end

  // coil store
  always_ff @(posedge clk) begin
    if (cmd.op == mrs_pkg::OP_CLEAR && clr_r < CLR_COIL) begin
      coil_mem[clr_r[CA-1:0]] <= 1'b0;
    end else if (cmd.op == mrs_pkg::OP_WR1 && fn == mrs_pkg::FN_WR_COIL) begin
      coil_mem[off_r[CA-1:0]] <= (cnt == mrs_pkg::COIL_ON);
    end
    crd_r <= coil_mem[caddr];
  end

  // reply store
  always_ff @(posedge clk) begin
    if (put_en && !rlen_r[8]) reply_mem[rlen_r[7:0]] <= put_byte;
    rrd_r <= reply_mem[ptr_r[7:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (recv) begin
      crc_ok_r <= (c1_r == {in_rx_byte, prev_r});
      if (!full) begin
        prev_r <= in_rx_byte;
        if (flen_r < HDR_BYTES) hdr_r[flen_r[2:0]] <= in_rx_byte;
      end
      len_r <= full ? 9'(flen_r) : 9'(flen_r) + 9'd1;
    end
    if (cmd.op == mrs_pkg::OP_DECODE) begin
      exc_r  <= exc_nxt;
      kind_r <= kind_nxt;
      off_r  <= adr - (is_hold_fn ? hbase_r : cbase_r);
    end
    if (cmd.op == mrs_pkg::OP_FR2) hi_r <= frd_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      flen_r     <= '0;
      ovf_r      <= 1'b0;
      ovf_seen_r <= 1'b0;
      fetch_r    <= 1'b0;
      c0_r       <= mrs_pkg::CRC_SEED;
      c1_r       <= mrs_pkg::CRC_SEED;
      st_r       <= mrs_pkg::ST_TAKEN;
      i_r        <= '0;
      k_r        <= '0;
      v_r        <= '0;
      crc_r      <= mrs_pkg::CRC_SEED;
      rlen_r     <= '0;
      ptr_r      <= '0;
      err_r      <= '0;
      req_r      <= '0;
    end else begin
      if (cmd.op == mrs_pkg::OP_CLEAR && !sts.clr_done) clr_r <= clr_r + 1'b1;

      if (cmd.accept) begin
        fetch_r <= in_command;
        st_r    <= (recv && full && !in_frame_end) ? mrs_pkg::ST_OVERFLOW :
                   mrs_pkg::ST_TAKEN;
      end
      if (recv) begin
        if (in_frame_end) begin
          // close the frame: drop old reply, empty the buffer
          ovf_seen_r <= ovf_r || full;
          flen_r     <= '0;
          ovf_r      <= 1'b0;
          c0_r       <= mrs_pkg::CRC_SEED;
          c1_r       <= mrs_pkg::CRC_SEED;
          rlen_r     <= '0;
          ptr_r      <= '0;
        end else if (full) begin
          ovf_r <= 1'b1;
        end else begin
          flen_r <= flen_r + 1'b1;
          c1_r   <= c0_r;
          c0_r   <= mrs_pkg::crc_byte(c0_r, in_rx_byte);
        end
      end

      case (cmd.op)
        mrs_pkg::OP_CLASSIFY: begin
          if (ovf_seen_r) st_r <= mrs_pkg::ST_OVERFLOW;
          else if (len_r < 9'd5) st_r <= mrs_pkg::ST_SHORT;
          else if (!crc_ok_r) begin
            st_r  <= mrs_pkg::ST_CRC_BAD;
            err_r <= err_r + 16'd1;
          end else if (!serve) st_r <= mrs_pkg::ST_NOT_ADDR;
        end
        mrs_pkg::OP_DECODE: begin
          crc_r <= mrs_pkg::CRC_SEED;
          if (exc_nxt != mrs_pkg::EXC_NONE) begin
            st_r  <= mrs_pkg::ST_EXCEPTION;
            err_r <= err_r + 16'd1;
          end else begin
            st_r  <= mrs_pkg::ST_REPLY;
            req_r <= req_r + 16'd1;
          end
        end
        mrs_pkg::OP_ROUTE: begin
          i_r <= '0;
          k_r <= '0;
          v_r <= '0;
        end
        mrs_pkg::OP_HDR: begin
          if (hdr_last) begin
            k_r <= '0;
            i_r <= '0;
          end else begin
            k_r <= k_r + 3'd1;
          end
        end
        mrs_pkg::OP_HLO, mrs_pkg::OP_FR3: i_r <= i_r + 12'd1;
        mrs_pkg::OP_CBIT: begin
          if ({4'd0, i_r} < cnt) v_r[i_r[2:0]] <= crd_r;
          i_r <= i_r + 12'd1;
        end
        mrs_pkg::OP_CPUT: v_r <= '0;
        mrs_pkg::OP_EMIT: begin
          if (fetch_r && ptr_r < rlen_r) ptr_r <= ptr_r + 9'd1;
        end
        default: ;
      endcase

      if (put_en && !rlen_r[8]) begin
        rlen_r <= rlen_r + 9'd1;
        if (put_crc) crc_r <= mrs_pkg::crc_byte(crc_r, put_byte);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == mrs_pkg::OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == mrs_pkg::OP_EMIT) begin
      if (fetch_r && ptr_r < rlen_r) begin
        tx_byte_r  <= rrd_r;
        tx_valid_r <= 1'b1;
        tx_last_r  <= (ptr_r + 9'd1 == rlen_r);
      end else begin
        tx_byte_r  <= 8'd0;
        tx_valid_r <= 1'b0;
        tx_last_r  <= 1'b0;
      end
      status_r  <= st_r;
      size_r    <= rlen_r;
      err_out_r <= err_r;
      req_out_r <= req_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tx_byte       = tx_byte_r;
  assign out_tx_valid      = tx_valid_r;
  assign out_tx_last       = tx_last_r;
  assign out_frame_status  = status_r;
  assign out_reply_size    = size_r;
  assign out_error_total   = err_out_r;
  assign out_request_total = req_out_r;

  `MRS_ASSERT_NOW(a_emit_free, cmd.op == mrs_pkg::OP_EMIT, !out_valid_r || !out_stall, "emit into a held output word")
  `MRS_ASSERT_NOW(a_ptr_in_reply, 1'b1, ptr_r <= rlen_r, "reply pointer past reply length")
  `MRS_ASSERT_NOW(a_reply_cap, 1'b1, rlen_r <= 9'd256, "reply length past capacity")
  `MRS_ASSERT_NEXT(a_close_empties, recv && in_frame_end, flen_r == '0 && ptr_r == '0, "frame close left state behind")

endmodule

>>> src/modbus_rtu_slave_responder_top.sv
// Receive word: accept, then the result word. Fetch word: accept, then the result word.
// Frame-end word: classify, then the result if not served; else also decode, route, WR1
// for a single write, header/echo bytes, HRD/HHI/HLO or FR1/FR2/FR3 per register, CRD/CBIT
// per coil bit read (rounded up to whole bytes), CPUT per coil byte, the CRC bytes, result.
// After reset a clearing sweep over max(HOLDING_DEPTH, COIL_DEPTH) addresses (2048 by
// default) zeroes the holding and coil stores; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// modbus_rtu_slave_responder_top
// Modbus RTU slave: frame collection, CRC/address checks, request service, reply.
// ----------------------------------------------------------------------------
module modbus_rtu_slave_responder_top #(
  parameter int FRAME_BYTES   = 256,
  parameter int HOLDING_DEPTH = 128,
  parameter int COIL_DEPTH    = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_tx_byte,
  output logic        out_tx_valid,
  output logic        out_tx_last,
  output logic [2:0]  out_frame_status,
  output logic [8:0]  out_reply_size,
  output logic [15:0] out_error_total,
  output logic [15:0] out_request_total,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  mrs_pkg::cmd_t cmd;
  mrs_pkg::sts_t sts;

  mrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mrs_dp #(
    .FRAME_BYTES   (FRAME_BYTES),
    .HOLDING_DEPTH (HOLDING_DEPTH),
    .COIL_DEPTH    (COIL_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_command        (in_command),
    .in_rx_byte        (in_rx_byte),
    .in_frame_end      (in_frame_end),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tx_byte       (out_tx_byte),
    .out_tx_valid      (out_tx_valid),
    .out_tx_last       (out_tx_last),
    .out_frame_status  (out_frame_status),
    .out_reply_size    (out_reply_size),
    .out_error_total   (out_error_total),
    .out_request_total (out_request_total)
  );

endmodule

>>> bench/mrs_word_checker.sv
// ----------------------------------------------------------------------------
// mrs_word_checker
// Watches both word channels and the config port of the Modbus RTU responder,
// keeps its own model of the frame, store and reply state, and checks every
// result word field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module mrs_word_checker
  import mrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_tx_byte,
  input  logic        out_tx_valid,
  input  logic        out_tx_last,
  input  logic [2:0]  out_frame_status,
  input  logic [8:0]  out_reply_size,
  input  logic [15:0] out_error_total,
  input  logic [15:0] out_request_total,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0]  tx_byte;
    logic        tx_valid;
    logic        tx_last;
    logic [2:0]  status;
    logic [8:0]  size;
    logic [15:0] errs;
    logic [15:0] reqs;
  } word_t;

  word_t expected_words[$];

  logic [7:0]  station;
  logic [15:0] hold_base, coil_base;
  logic [7:0]  hold_count;
  logic [11:0] coil_count;

  logic [7:0]  frm[256];
  int unsigned frm_len;
  bit          frm_ovf;
  logic [15:0] hold[128];
  bit          coil[2048];
  logic [7:0]  rep[256];
  int unsigned rep_len, rep_ptr;
  logic [15:0] err_tally, req_tally;

  initial fail_count = 0;
  initial pending = 0;

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h, predicted %0h (t=%0t)", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [15:0] crc_of(bit over_reply, int unsigned n);
    logic [15:0] c;
    c = CRC_SEED;
    for (int unsigned i = 0; i < n; i++) begin
      c = c ^ {8'h00, (over_reply ? rep[i] : frm[i])};
      for (int b = 0; b < 8; b++)
        c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void reply_put(logic [7:0] v);
    if (rep_len < 256) begin
      rep[rep_len] = v;
      rep_len++;
    end
  endfunction

  function automatic void reply_seal();
    logic [15:0] c;
    c = crc_of(1'b1, rep_len);
    reply_put(c[7:0]);
    reply_put(c[15:8]);
  endfunction

  function automatic int unsigned frame_word(int unsigned p);
    return {frm[p], frm[p + 1]};
  endfunction

  // returns the exception code, none when served
  function automatic logic [1:0] serve_request(int unsigned len);
    int unsigned fn, adr, cnt, bc, top, off, nb, v, idx;
    fn = frm[1];
    if (fn != FN_RD_COILS && fn != FN_RD_HOLD && fn != FN_WR_COIL &&
        fn != FN_WR_HOLD && fn != FN_WR_MULTI)
      return EXC_FUNC;
    if (len < 8) return EXC_VALUE;
    adr = frame_word(2);
    cnt = frame_word(4);
    if (fn == FN_RD_HOLD || fn == FN_WR_HOLD || fn == FN_WR_MULTI) begin
      top = hold_base + (hold_count < 128 ? hold_count : 128);
      if (fn == FN_RD_HOLD && (cnt == 0 || cnt > 125)) return EXC_VALUE;
      if (fn == FN_WR_MULTI) begin
        if (len < 9) return EXC_VALUE;
        bc = frm[6];
        if (cnt == 0 || cnt > 123 || bc != cnt * 2 || len < 9 + bc) return EXC_VALUE;
      end
      if (adr < hold_base || adr >= top) return EXC_ADDR;
      off = adr - hold_base;
      if (fn == FN_WR_HOLD) begin
        hold[off] = cnt[15:0];
        for (int i = 0; i < 6; i++) reply_put(frm[i]);
      end else begin
        if (adr + cnt > top) return EXC_ADDR;
        reply_put(station);
        reply_put(8'(fn));
        if (fn == FN_RD_HOLD) begin
          reply_put(8'(cnt * 2));
          for (int unsigned i = 0; i < cnt; i++) begin
            reply_put(hold[off + i][15:8]);
            reply_put(hold[off + i][7:0]);
          end
        end else begin
          for (int unsigned i = 0; i < cnt; i++)
            hold[off + i] = 16'(frame_word(7 + 2 * i));
          reply_put(8'(adr >> 8));
          reply_put(8'(adr));
          reply_put(8'(cnt >> 8));
          reply_put(8'(cnt));
        end
      end
    end else begin
      top = coil_base + (coil_count < 2048 ? coil_count : 2048);
      if (fn == FN_RD_COILS && (cnt == 0 || cnt > 2000)) return EXC_VALUE;
      if (adr < coil_base || adr >= top) return EXC_ADDR;
      off = adr - coil_base;
      if (fn == FN_WR_COIL) begin
        coil[off] = (cnt == COIL_ON);
        for (int i = 0; i < 6; i++) reply_put(frm[i]);
      end else begin
        if (adr + cnt > top) return EXC_ADDR;
        nb = (cnt + 7) / 8;
        reply_put(station);
        reply_put(8'(fn));
        reply_put(8'(nb));
        for (int unsigned j = 0; j < nb; j++) begin
          v = 0;
          for (int unsigned k = 0; k < 8; k++) begin
            idx = j * 8 + k;
            if (idx < cnt && coil[off + idx]) v = v | (1 << k);
          end
          reply_put(8'(v));
        end
      end
    end
    reply_seal();
    return EXC_NONE;
  endfunction

  function automatic logic [2:0] close_frame();
    int unsigned len;
    logic [1:0]  ex;
    logic [2:0]  st;
    len = frm_len;
    rep_len = 0;
    rep_ptr = 0;
    if (frm_ovf) begin
      st = ST_OVERFLOW;
    end else if (len < 5) begin
      st = ST_SHORT;
    end else if ({frm[len - 1], frm[len - 2]} != crc_of(1'b0, len - 2)) begin
      err_tally++;
      st = ST_CRC_BAD;
    end else if (frm[0] != station) begin
      st = ST_NOT_ADDR;
    end else begin
      ex = serve_request(len);
      if (ex != EXC_NONE) begin
        rep_len = 0;
        reply_put(station);
        reply_put(frm[1] | EXC_FLAG);
        reply_put(8'(ex));
        reply_seal();
        err_tally++;
        st = ST_EXCEPTION;
      end else begin
        req_tally++;
        st = ST_REPLY;
      end
    end
    frm_len = 0;
    frm_ovf = 0;
    return st;
  endfunction

  function automatic word_t slave_reply_step(logic cmd, logic [7:0] rx, logic fe);
    word_t w;
    w = '0;
    if (cmd) begin
      if (rep_ptr < rep_len) begin
        w.tx_byte  = rep[rep_ptr];
        w.tx_valid = 1'b1;
        w.tx_last  = (rep_ptr + 1 == rep_len);
        rep_ptr++;
      end
    end else begin
      if (frm_len < 256) begin
        frm[frm_len] = rx;
        frm_len++;
      end else begin
        frm_ovf = 1;
        w.status = ST_OVERFLOW;
      end
      if (fe) w.status = close_frame();
    end
    w.size = 9'(rep_len);
    w.errs = err_tally;
    w.reqs = req_tally;
    return w;
  endfunction

  always @(posedge clk) begin
    word_t want;
    if (!rst_n) begin
      station = 8'd1;
      hold_base = '0;
      hold_count = '0;
      coil_base = '0;
      coil_count = '0;
      frm_len = 0;
      frm_ovf = 0;
      rep_len = 0;
      rep_ptr = 0;
      err_tally = '0;
      req_tally = '0;
      foreach (hold[i]) hold[i] = '0;
      foreach (coil[i]) coil[i] = 0;
      expected_words.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_STATION:    station = cfg_wdata[7:0];
          CFG_HOLD_BASE:  hold_base = cfg_wdata;
          CFG_HOLD_COUNT: hold_count = cfg_wdata[7:0];
          CFG_COIL_BASE:  coil_base = cfg_wdata;
          CFG_COIL_COUNT: coil_count = cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report("unexpected word, status", 16'(out_frame_status), 16'h0);
        end else begin
          want = expected_words.pop_front();
          if (out_tx_byte !== want.tx_byte) report("tx_byte", 16'(out_tx_byte), 16'(want.tx_byte));
          if (out_tx_valid !== want.tx_valid)
            report("tx_valid", 16'(out_tx_valid), 16'(want.tx_valid));
          if (out_tx_last !== want.tx_last) report("tx_last", 16'(out_tx_last), 16'(want.tx_last));
          if (out_frame_status !== want.status)
            report("frame_status", 16'(out_frame_status), 16'(want.status));
          if (out_reply_size !== want.size)
            report("reply_size", 16'(out_reply_size), 16'(want.size));
          if (out_error_total !== want.errs) report("error_total", out_error_total, want.errs);
          if (out_request_total !== want.reqs)
            report("request_total", out_request_total, want.reqs);
        end
      end
      if (in_valid && !in_stall)
        expected_words.push_back(slave_reply_step(in_command, in_rx_byte, in_frame_end));
    end
    pending = expected_words.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives Modbus request frames, reply fetches and config phases into the RTU
// slave responder under varied idle and stall patterns; the checker predicts.
// ----------------------------------------------------------------------------
module tb_top;
  import mrs_pkg::*;

  localparam int QUIET_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_tx_valid;
  logic        out_tx_last;
  logic [2:0]  out_frame_status;
  logic [8:0]  out_reply_size;
  logic [15:0] out_error_total;
  logic [15:0] out_request_total;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int fail_count, pending;
  int idle_pct = 0, stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit long_hold = 0, hold_done = 0;

  int unsigned cur_station, cur_hbase, cur_hcount, cur_cbase, cur_ccount;
  logic [7:0] req_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modbus_rtu_slave_responder_top i_dut (.*);

  mrs_word_checker i_checker (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold && !hold_done) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_done = 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_word(logic cmd, logic [7:0] b, logic fe);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_rx_byte <= b;
    in_frame_end <= fe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (req_bytes[i]) send_word(1'b0, req_bytes[i], i == req_bytes.size() - 1);
  endtask

  task automatic fetch_words(int n);
    // rx_byte is ignored on a fetch; keep it random
    repeat (n) send_word(1'b1, 8'($urandom), 1'($urandom));
  endtask

  task automatic append_crc();
    logic [15:0] c;
    c = CRC_SEED;
    foreach (req_bytes[i]) begin
      c = c ^ {8'h00, req_bytes[i]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    req_bytes.push_back(c[7:0]);
    req_bytes.push_back(c[15:8]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_config(int unsigned st, hb, hc, cb, cc);
    logic [15:0] vals[5];
    vals = '{16'(st), 16'(hb), 16'(hc), 16'(cb), 16'(cc)};
    cur_station = st; cur_hbase = hb; cur_hcount = hc; cur_cbase = cb; cur_ccount = cc;
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic build_request();
    int unsigned kind, pick, fn, adr, cnt, span, base, bc, r;
    logic [7:0] fns[5];
    fns = '{FN_RD_COILS, FN_RD_HOLD, FN_WR_COIL, FN_WR_HOLD, FN_WR_MULTI};
    req_bytes.delete();
    kind = $urandom_range(99);
    pick = $urandom_range(4);
    fn = (kind < 4) ? $urandom_range(255) : fns[pick];
    if (fn == FN_RD_COILS || fn == FN_WR_COIL) begin
      base = cur_cbase;
      span = cur_ccount < 2048 ? cur_ccount : 2048;
    end else begin
      base = cur_hbase;
      span = cur_hcount < 128 ? cur_hcount : 128;
    end
    if ($urandom_range(9) < 8) adr = (base + $urandom_range(0, span > 0 ? span - 1 : 0)) & 16'hFFFF;
    else adr = $urandom_range(16'hFFFF);
    r = $urandom_range(99);
    if (r < 80) cnt = $urandom_range(1, 8);
    else if (r < 88) cnt = (fn == FN_RD_COILS) ? $urandom_range(1, 2010) :
                           (fn == FN_WR_MULTI) ? $urandom_range(100, 125) : $urandom_range(100, 130);
    else if (r < 93) cnt = 0;
    else cnt = $urandom_range(16'hFFFF);
    if (fn == FN_WR_HOLD) cnt = $urandom_range(16'hFFFF);
    if (fn == FN_WR_COIL) cnt = $urandom_range(1) ? COIL_ON : $urandom_range(16'hFFFF);
    req_bytes.push_back((kind >= 4 && kind < 8) ? 8'($urandom) : 8'(cur_station));
    req_bytes.push_back(8'(fn));
    req_bytes.push_back(8'(adr >> 8));
    req_bytes.push_back(8'(adr));
    req_bytes.push_back(8'(cnt >> 8));
    req_bytes.push_back(8'(cnt));
    if (fn == FN_WR_MULTI) begin
      bc = ($urandom_range(9) == 0) ? $urandom_range(255) : (cnt * 2) & 8'hFF;
      req_bytes.push_back(8'(bc));
      repeat (bc) req_bytes.push_back(8'($urandom));
    end
    if (kind >= 8 && kind < 12) repeat ($urandom_range(1, 3)) req_bytes.push_back(8'($urandom));
    // truncated request, still with a good CRC
    if (kind >= 12 && kind < 18) begin
      r = $urandom_range(0, req_bytes.size() - 1);
      while (req_bytes.size() > r) void'(req_bytes.pop_back());
    end
    if (kind >= 24 && kind < 27) begin
      req_bytes.delete();
      repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom));
    end else begin
      append_crc();
      if (kind >= 18 && kind < 24) req_bytes[req_bytes.size() - 2] ^= 8'($urandom_range(1, 255));
    end
  endtask

  task automatic random_requests(int target);
    int stop_at;
    stop_at = items_sent + target;
    while (items_sent < stop_at) begin
      build_request();
      send_frame();
      fetch_words(($urandom_range(4) == 0) ? 24 : $urandom_range(0, 8));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(1, 0, 128, 0, 2048);
    // directed: fetch with no reply, too-short frame, write then read the top register
    fetch_words(1);
    req_bytes = '{8'h00, 8'hFF};
    send_frame();
    req_bytes = '{8'h01, FN_WR_HOLD, 8'h00, 8'h7F, 8'hFF, 8'hFF};
    append_crc();
    send_frame();
    req_bytes = '{8'h01, FN_RD_HOLD, 8'h00, 8'h7F, 8'h00, 8'h01};
    append_crc();
    send_frame();
    fetch_words(4);
    long_hold = 1;
    random_requests(30);

    for (int phase = 1; phase < 6; phase++) begin
      drain();
      case (phase)
        1: set_config(255, 16'hFF80, 255, 16'hFFFF, 4095);
        2: set_config(0, 1000, 0, 40, 0);
        3: set_config($urandom_range(255), $urandom_range(16'hFFFF), $urandom_range(255),
                      $urandom_range(16'hFFFF), $urandom_range(4095));
        4: set_config(1, 0, 10, 100, 2000);
        default: set_config(7, 0, 128, 0, 2048);
      endcase
      idle_pct  = (phase % 4 == 1) ? 59 : (phase % 4 == 3) ? 16 : 0;
      stall_pct = (phase % 4 == 2) ? 59 : (phase % 4 == 3) ? 16 : 0;
      if (phase == 2) begin
        // overflow the frame buffer
        req_bytes.delete();
        repeat (260) req_bytes.push_back(8'($urandom));
        send_frame();
      end
      random_requests(15);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
